// ===== src/glob_wildcard_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// Glob wildcard matcher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define GWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Command codes, field widths and pattern metacharacters.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int CMD_W           = 2;
    localparam int SYM_W           = 8;
    localparam int COUNT_W         = 6;
    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [SYM_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [SYM_W-1:0] CH_QUESTION = 8'h3F;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_START  = 2'd3
    } cmd_t;

endpackage

// ===== src/glob_wildcard_matcher.sv =====
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Streams text bytes against a stored glob pattern ('*' any run, '?' one
// byte, anything else literal) using a bit-parallel active-position vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command: clear the
//   pattern, append a pattern byte, consume a text byte, or start a new text.
//   Output channel (out_valid/out_ready) returns exactly one beat per input
//   beat: match_now, pattern_overflow and pattern_count after that command.
//   The accepting edge loads the input register; the result register loads
//   from it once the output channel is free. Throughput is one beat per cycle
//   while out_ready stays high, as the position update (per-position compare
//   plus a log-depth star-closure prefix network) is combinational.
//   Reset empties the pattern, clears overflow and restarts the text, so an
//   empty text matches the empty pattern; both channels come up empty.
//   When the receiver stalls, the result register holds its beat, the input
//   register keeps one more beat, and in_ready drops until out_ready returns.
//   Appending past MAX_PATTERN bytes drops the byte and sets overflow.
// ----------------------------------------------------------------------------
`include "glob_wildcard_matcher_macros.svh"

module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [SYM_W-1:0]   symbol,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               match_now,
    output logic               pattern_overflow,
    output logic [COUNT_W-1:0] pattern_count
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEVELS = $clog2(MAX_PATTERN + 1);

    logic               s1_valid_reg;
    logic [CMD_W-1:0]   s1_cmd_reg;
    logic [SYM_W-1:0]   s1_sym_reg;

    logic [SYM_W-1:0]   pat_reg [MAX_PATTERN];
    logic [LEN_W-1:0]   len_reg;
    logic               ovf_reg;
    logic [MAX_PATTERN:0] active_reg;

    logic               out_valid_reg;
    logic               match_reg;
    logic               ovf_out_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               adv;
    cmd_t               cmd;
    logic               full;
    logic               append_ok;
    logic [LEN_W-1:0]   len_next;
    logic               ovf_next;
    logic [SYM_W-1:0]   byte_new [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] live_new;
    logic [MAX_PATTERN-1:0] star_new;
    logic [MAX_PATTERN:0] step_vec;
    logic [MAX_PATTERN:0] seed_vec;
    logic [MAX_PATTERN:0] g_lvl [LEVELS+1];
    logic [MAX_PATTERN:0] p_lvl [LEVELS+1];
    logic [MAX_PATTERN:0] active_next;
    logic               match_next;

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    assign cmd       = cmd_t'(s1_cmd_reg);
    assign full      = (len_reg == LEN_W'(MAX_PATTERN));
    assign append_ok = (cmd == CMD_APPEND) && !full;

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        unique case (cmd)
            CMD_CLEAR:
            begin
                len_next = '0;
                ovf_next = 1'b0;
            end
            CMD_APPEND:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            CMD_TEXT:
            begin
                len_next = len_reg;
            end
            CMD_START:
            begin
                len_next = len_reg;
            end
        endcase
    end

    // Pattern view after this beat, per position
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            byte_new[i] = (append_ok && (len_reg == LEN_W'(i))) ? s1_sym_reg : pat_reg[i];
            live_new[i] = (LEN_W'(i) < len_next);
            star_new[i] = live_new[i] && (byte_new[i] == CH_STAR);
        end
    end

    // Advance active positions by one text byte
    always_comb
    begin
        step_vec = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (active_reg[i] && live_new[i])
            begin
                if (byte_new[i] == CH_STAR)
                begin
                    step_vec[i] = 1'b1;
                end
                else if ((byte_new[i] == CH_QUESTION) || (byte_new[i] == s1_sym_reg))
                begin
                    step_vec[i + 1] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        unique case (cmd)
            CMD_TEXT:   seed_vec = step_vec;
            CMD_CLEAR:  seed_vec = (MAX_PATTERN + 1)'(1);
            CMD_APPEND: seed_vec = (MAX_PATTERN + 1)'(1);
            CMD_START:  seed_vec = (MAX_PATTERN + 1)'(1);
        endcase
    end

    // Star closure as a prefix network: propagate across each live star
    always_comb
    begin
        g_lvl[0] = seed_vec;
        p_lvl[0] = {star_new, 1'b0};
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int j = 0; j <= MAX_PATTERN; j++)
            begin
                if (j >= (1 << l))
                begin
                    g_lvl[l + 1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
                    p_lvl[l + 1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
                end
                else
                begin
                    g_lvl[l + 1][j] = g_lvl[l][j];
                    p_lvl[l + 1][j] = p_lvl[l][j];
                end
            end
        end
    end

    assign active_next = g_lvl[LEVELS];
    assign match_next  = active_next[len_next];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg <= command;
            s1_sym_reg <= symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            active_reg <= (MAX_PATTERN + 1)'(1);
        end
        else if (adv)
        begin
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && append_ok)
        begin
            pat_reg[len_reg[IDX_W-1:0]] <= s1_sym_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            match_reg   <= match_next;
            ovf_out_reg <= ovf_next;
            count_reg   <= COUNT_W'(len_next);
        end
    end

    assign out_valid        = out_valid_reg;
    assign match_now        = match_reg;
    assign pattern_overflow = ovf_out_reg;
    assign pattern_count    = count_reg;

    `GWM_ASSERT_NEXT(a_clear_empties, adv && (cmd == CMD_CLEAR), out_valid && (pattern_count == '0) && !pattern_overflow, "clear beat did not empty the pattern")
    `GWM_ASSERT_NEXT(a_full_append_overflows, adv && (cmd == CMD_APPEND) && full, ovf_reg && pattern_overflow && ($past(len_reg) == len_reg), "append to a full store did not flag overflow")
    `GWM_ASSERT_NEXT(a_empty_start_matches, adv && (cmd == CMD_START) && (len_reg == '0), match_now, "empty text failed to match the empty pattern")
    `GWM_ASSERT_NEXT(a_restart_seeds_origin, adv && (cmd != CMD_TEXT), active_reg[0], "text restart lost the origin position")

endmodule
